// File: hdl/utf8_stream_decoder_top_macros.svh
// assertion macros used by the utf8 stream decoder top level
`ifndef UTF8_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_STREAM_DECODER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// property holds in the same cycle
`define UTF8SD_ASSERT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// property holds in the following cycle
`define UTF8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define UTF8SD_ASSERT(label, clk, rst_n, ante, cons, msg)
`define UTF8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hdl/utf8sd_pkg.sv
// types and constants of the utf8 stream decoder
package utf8sd_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [20:0] cp_t;
	typedef logic [2:0]  status_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_BAD_LEAD  = 3'd1;
	localparam status_t ST_BAD_CONT  = 3'd2;
	localparam status_t ST_OVERLONG  = 3'd3;
	localparam status_t ST_SURROGATE = 3'd4;
	localparam status_t ST_RANGE     = 3'd5;
	localparam status_t ST_TRUNC     = 3'd6;

	localparam logic [2:0] SEQ_NONE = 3'd0;
	localparam logic [2:0] SEQ_2B   = 3'd2;
	localparam logic [2:0] SEQ_3B   = 3'd3;
	localparam logic [2:0] SEQ_4B   = 3'd4;

	localparam cp_t MIN_2B  = 21'h000080;
	localparam cp_t MIN_3B  = 21'h000800;
	localparam cp_t MIN_4B  = 21'h010000;
	localparam cp_t SURR_LO = 21'h00D800;
	localparam cp_t SURR_HI = 21'h00DFFF;
	localparam cp_t CP_MAX  = 21'h10FFFF;

	typedef struct packed {
		logic [1:0] pending;
		cp_t        value;
		logic [2:0] seq_len;
		logic       discarding;
	} dec_state_t;

	typedef struct packed {
		logic    valid;
		cp_t     code_point;
		status_t status;
		logic    ends_string;
	} dec_result_t;

endpackage

// File: hdl/utf8sd_in_if.sv
// byte input channel of the utf8 stream decoder
interface utf8sd_in_if
	import utf8sd_pkg::*;
();
	logic  valid;
	logic  ready;
	byte_t in_byte;
	logic  string_end;

	modport source (output valid, output in_byte, output string_end, input ready);
	modport sink (input valid, input in_byte, input string_end, output ready);
endinterface

// File: hdl/utf8sd_out_if.sv
// code point output channel of the utf8 stream decoder
interface utf8sd_out_if
	import utf8sd_pkg::*;
();
	logic    valid;
	logic    ready;
	cp_t     code_point;
	status_t status;
	logic    ends_string;

	modport source (output valid, output code_point, output status, output ends_string,
		input ready);
	modport sink (input valid, input code_point, input status, input ends_string,
		output ready);
endinterface

// File: hdl/utf8sd_decode.sv
// per-byte decode step: next decoder state and the optional result
module utf8sd_decode
	import utf8sd_pkg::*;
(
	input  dec_state_t  cur,
	input  byte_t       in_byte,
	input  logic        string_end,
	output dec_state_t  nxt,
	output dec_result_t res
);

	logic    do_emit;
	status_t st;
	cp_t     cp;
	cp_t     acc;
	cp_t     minimum;
	logic    [1:0] pend_dec;

	assign acc      = {cur.value[14:0], in_byte[5:0]};
	assign pend_dec = cur.pending - 2'd1;

	always_comb begin
		unique case (cur.seq_len)
			SEQ_2B:  minimum = MIN_2B;
			SEQ_3B:  minimum = MIN_3B;
			default: minimum = MIN_4B;
		endcase
	end

	always_comb begin
		nxt     = cur;
		do_emit = 1'b0;
		st      = ST_OK;
		cp      = '0;
		if (cur.discarding) begin
			// drop silently until the string ends
			if (string_end) begin
				nxt = '0;
			end
		end else if (cur.pending == 2'd0) begin
			priority if (in_byte[7] == 1'b0) begin
				do_emit = 1'b1;
				cp      = {13'd0, in_byte};
			end else if (in_byte[7:5] == 3'b110) begin
				nxt.seq_len = SEQ_2B;
				nxt.pending = 2'd1;
				nxt.value   = {16'd0, in_byte[4:0]};
			end else if (in_byte[7:4] == 4'b1110) begin
				nxt.seq_len = SEQ_3B;
				nxt.pending = 2'd2;
				nxt.value   = {17'd0, in_byte[3:0]};
			end else if (in_byte[7:3] == 5'b11110) begin
				nxt.seq_len = SEQ_4B;
				nxt.pending = 2'd3;
				nxt.value   = {18'd0, in_byte[2:0]};
			end else begin
				do_emit = 1'b1;
				st      = ST_BAD_LEAD;
			end
			if (!do_emit && string_end) begin
				do_emit = 1'b1;
				st      = ST_TRUNC;
			end
		end else if (in_byte[7:6] != 2'b10) begin
			do_emit = 1'b1;
			st      = ST_BAD_CONT;
		end else begin
			nxt.value   = acc;
			nxt.pending = pend_dec;
			if (pend_dec != 2'd0) begin
				if (string_end) begin
					do_emit = 1'b1;
					st      = ST_TRUNC;
				end
			end else begin
				do_emit = 1'b1;
				priority if (acc < minimum) begin
					st = ST_OVERLONG;
				end else if (acc >= SURR_LO && acc <= SURR_HI) begin
					st = ST_SURROGATE;
				end else if (acc > CP_MAX) begin
					st = ST_RANGE;
				end else begin
					cp = acc;
				end
			end
		end
		if (do_emit) begin
			nxt.pending    = 2'd0;
			nxt.value      = '0;
			nxt.seq_len    = SEQ_NONE;
			nxt.discarding = (st != ST_OK) && !string_end;
		end
	end

	assign res.valid       = do_emit;
	assign res.code_point  = cp;
	assign res.status      = st;
	assign res.ends_string = string_end;

endmodule

// File: hdl/utf8_stream_decoder_top.sv
// UTF-8 byte stream decoder, top level
// Takes one UTF-8 byte per transfer, flagged when it is the last byte of a string, and
// gives one result per completed code point or detected error (status nonzero, code
// point zero); after an error the rest of that string is dropped with no result. The
// decode step is one pass of logic from the state registers into the result register,
// and a byte is taken in every cycle in which the result register is empty or its
// result is being taken in the same cycle. A result is registered and appears on the
// output in the cycle after the byte that caused it is taken.
`include "utf8_stream_decoder_top_macros.svh"

module utf8_stream_decoder_top
	import utf8sd_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	utf8sd_in_if.sink    byte_ch,
	utf8sd_out_if.source cp_ch
);

	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res;
	logic        accept;

	logic    out_valid_q;
	cp_t     out_cp_q;
	status_t out_status_q;
	logic    out_end_q;

	utf8sd_decode u_decode (
		.cur        (state_q),
		.in_byte    (byte_ch.in_byte),
		.string_end (byte_ch.string_end),
		.nxt        (state_nxt),
		.res        (res)
	);

	// result register frees up in the same cycle its transfer completes
	assign byte_ch.ready = !out_valid_q || cp_ch.ready;
	assign accept        = byte_ch.valid && byte_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (cp_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res.valid) begin
			out_cp_q     <= res.code_point;
			out_status_q <= res.status;
			out_end_q    <= res.ends_string;
		end
	end

	assign cp_ch.valid       = out_valid_q;
	assign cp_ch.code_point  = out_cp_q;
	assign cp_ch.status      = out_status_q;
	assign cp_ch.ends_string = out_end_q;

	`UTF8SD_ASSERT(a_err_zero_cp, clk, arst_n, out_valid_q && out_status_q != ST_OK, out_cp_q == '0, "error result with nonzero code point")
	`UTF8SD_ASSERT(a_ok_scalar, clk, arst_n, out_valid_q && out_status_q == ST_OK, out_cp_q <= CP_MAX && !(out_cp_q >= SURR_LO && out_cp_q <= SURR_HI), "ok result is not a scalar value")
	`UTF8SD_ASSERT(a_pending_seq, clk, arst_n, state_q.pending != 2'd0, state_q.seq_len != SEQ_NONE && !state_q.discarding, "pending bytes without an open sequence")
	`UTF8SD_ASSERT_NEXT(a_end_idle, clk, arst_n, accept && byte_ch.string_end, state_q == '0, "decoder not idle after last byte of string")

endmodule
